// ===== src/lrukv_pkg.sv =====
// ----------------------------------------------------------------------------
// lrukv_pkg: shared definitions for the lru key/value cache
// operation codes, fixed field widths, the capacity reset value and the miss read value
// ----------------------------------------------------------------------------
package lrukv_pkg;

   // fixed field widths
   localparam int VALUE_BITS = 32;
   localparam int PORT_KEY_BITS = 32;
   localparam int CAP_BITS = 5;

   // capacity register after reset
   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   // operation codes
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   // read value returned by a get that misses
   localparam logic signed [VALUE_BITS-1:0] MISS_VALUE = -32'sd1;

endpackage

// ===== src/lru_key_value_cache.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key/value store, lru replacement
// one sequencer walks the entries through a single compare/rank unit
// ----------------------------------------------------------------------------
// Usage:
//  - an item (req_op, req_key, req_value) is taken at a clock edge with
//    start high and busy low; busy stays high while the item is worked on
//  - req_op get: one result on rsp_hit / rsp_read_value, marked by
//    rsp_strobe for one cycle; a miss gives hit 0 and read value -1
//  - req_op put: overwrite a present key or insert a new one, evicting the
//    least recent entries once the valid count reaches the capacity; no result
//  - csr_write_enable / csr_write_data write the capacity register
//    (0 acts as 1, values above MAX_ENTRIES act as MAX_ENTRIES)
//  - sequence: the get result follows two passes (search, then rank update)
//    over the entry memories, each entry taking a registered memory read and
//    then a compare or a write back; a new item is taken only once both passes
//    over the last item are done and the sequencer is idle again
//  - reset (synchronous, active high) empties the store and sets capacity 16
//  - the receiver cannot stall: a result is valid only in its strobe cycle
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
   parameter int MAX_ENTRIES = 16,
   parameter int KEY_BITS = 32
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   output logic                                       busy,
   input  logic                                       req_op,
   input  logic signed [lrukv_pkg::PORT_KEY_BITS-1:0] req_key,
   input  logic signed [lrukv_pkg::VALUE_BITS-1:0]    req_value,
   output logic                                       rsp_strobe,
   output logic                                       rsp_hit,
   output logic signed [lrukv_pkg::VALUE_BITS-1:0]    rsp_read_value,
   input  logic                                       csr_write_enable,
   input  logic [lrukv_pkg::CAP_BITS-1:0]             csr_write_data
);

   // derived widths
   localparam int KW = (KEY_BITS < lrukv_pkg::PORT_KEY_BITS) ? KEY_BITS
                                                             : lrukv_pkg::PORT_KEY_BITS;
   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int EW = (CW > lrukv_pkg::CAP_BITS) ? CW : lrukv_pkg::CAP_BITS;
   localparam int VW = lrukv_pkg::VALUE_BITS;
   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);
   localparam logic [EW-1:0] MAX_CAP = EW'(MAX_ENTRIES);

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_S_RD   = 3'd1;
   localparam logic [2:0] ST_S_CMP  = 3'd2;
   localparam logic [2:0] ST_U_RD   = 3'd3;
   localparam logic [2:0] ST_U_WR   = 3'd4;

   // entry memories
   logic [KW-1:0] key_mem  [MAX_ENTRIES];
   logic [VW-1:0] val_mem  [MAX_ENTRIES];
   logic [IW-1:0] rank_mem [MAX_ENTRIES];

   // registers
   logic [2:0]                   state_ff, state_in;
   logic [IW-1:0]                idx_ff, idx_in;
   logic                         op_ff, op_in;
   logic [KW-1:0]                key_ff, key_in;
   logic [VW-1:0]                val_ff, val_in;
   logic                         found_ff, found_in;
   logic [IW-1:0]                match_idx_ff, match_idx_in;
   logic [IW-1:0]                match_rank_ff, match_rank_in;
   logic [VW-1:0]                match_val_ff, match_val_in;
   logic                         slot_taken_ff, slot_taken_in;
   logic                         do_evict_ff, do_evict_in;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic [MAX_ENTRIES-1:0]       valid_ff, valid_in;
   logic [lrukv_pkg::CAP_BITS-1:0] cap_ff;
   logic                         rsp_strobe_ff, rsp_strobe_in;
   logic                         rsp_hit_ff, rsp_hit_in;
   logic [VW-1:0]                rsp_val_ff, rsp_val_in;
   logic [KW-1:0]                rd_key_ff;
   logic [VW-1:0]                rd_val_ff;
   logic [IW-1:0]                rd_rank_ff;

   // memory write controls
   logic          kv_wr_en;
   logic          val_wr_en;
   logic          rank_wr_en;
   logic [IW-1:0] rank_wr_data;

   // effective capacity and per-entry decisions
   logic [EW-1:0] cap_ext;
   logic [EW-1:0] eff_cap;
   logic          cur_valid;
   logic          evict_i;
   logic          insert_i;

   // capacity clamp: zero acts as one, above the store acts as full size
   always_comb begin
      cap_ext = EW'(cap_ff);
      if (cap_ext == '0) begin
         eff_cap = EW'(1);
      end else if (cap_ext > MAX_CAP) begin
         eff_cap = MAX_CAP;
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign cur_valid = valid_ff[idx_ff];

   // eviction and free slot choice for a put of a new key
   always_comb begin
      evict_i = do_evict_ff && cur_valid && (EW'(rd_rank_ff) >= (eff_cap - EW'(1)));
      insert_i = !(cur_valid && !evict_i) && !slot_taken_ff;
   end

   // sequencer and the shared compare/rank unit
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      found_in      = found_ff;
      match_idx_in  = match_idx_ff;
      match_rank_in = match_rank_ff;
      match_val_in  = match_val_ff;
      slot_taken_in = slot_taken_ff;
      do_evict_in   = do_evict_ff;
      cnt_in        = cnt_ff;
      valid_in      = valid_ff;
      rsp_strobe_in = 1'b0;
      rsp_hit_in    = rsp_hit_ff;
      rsp_val_in    = rsp_val_ff;
      kv_wr_en      = 1'b0;
      val_wr_en     = 1'b0;
      rank_wr_en    = 1'b0;
      rank_wr_data  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in         = req_op;
               key_in        = req_key[KW-1:0];
               val_in        = req_value;
               found_in      = 1'b0;
               slot_taken_in = 1'b0;
               idx_in        = '0;
               state_in      = ST_S_RD;
            end
         end
         ST_S_RD: begin
            state_in = ST_S_CMP;
         end
         ST_S_CMP: begin
            // key compare against the entry just read
            if (cur_valid && (rd_key_ff == key_ff) && !found_ff) begin
               found_in      = 1'b1;
               match_idx_in  = idx_ff;
               match_rank_in = rd_rank_ff;
               match_val_in  = rd_val_ff;
            end
            if (idx_ff == LAST_IDX) begin
               idx_in      = '0;
               do_evict_in = (EW'(cnt_ff) >= eff_cap);
               state_in    = ST_U_RD;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_S_RD;
            end
         end
         ST_U_RD: begin
            state_in = ST_U_WR;
         end
         ST_U_WR: begin
            if (found_ff) begin
               // hit: move the entry to the front, age the more recent ones
               if (idx_ff == match_idx_ff) begin
                  rank_wr_en   = 1'b1;
                  rank_wr_data = '0;
                  val_wr_en    = (op_ff == lrukv_pkg::OP_PUT);
               end else if (cur_valid && (rd_rank_ff < match_rank_ff)) begin
                  rank_wr_en   = 1'b1;
                  rank_wr_data = rd_rank_ff + 1'b1;
               end
            end else if (op_ff == lrukv_pkg::OP_PUT) begin
               // new key: evict, age survivors, fill lowest free slot
               if (insert_i) begin
                  kv_wr_en          = 1'b1;
                  rank_wr_en        = 1'b1;
                  rank_wr_data      = '0;
                  valid_in[idx_ff]  = 1'b1;
                  slot_taken_in     = 1'b1;
               end else if (evict_i) begin
                  valid_in[idx_ff] = 1'b0;
               end else if (cur_valid) begin
                  rank_wr_en   = 1'b1;
                  rank_wr_data = rd_rank_ff + 1'b1;
               end
               cnt_in = cnt_ff - CW'(evict_i) + CW'(insert_i);
            end
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = ST_IDLE;
               if (op_ff == lrukv_pkg::OP_GET) begin
                  rsp_strobe_in = 1'b1;
                  rsp_hit_in    = found_ff;
                  rsp_val_in    = found_ff ? match_val_ff : lrukv_pkg::MISS_VALUE;
               end
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_U_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         found_ff      <= 1'b0;
         slot_taken_ff <= 1'b0;
         do_evict_ff   <= 1'b0;
         cnt_ff        <= '0;
         valid_ff      <= '0;
         cap_ff        <= lrukv_pkg::CAP_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         found_ff      <= found_in;
         slot_taken_ff <= slot_taken_in;
         do_evict_ff   <= do_evict_in;
         cnt_ff        <= cnt_in;
         valid_ff      <= valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_write_enable) begin
            cap_ff <= csr_write_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      match_idx_ff  <= match_idx_in;
      match_rank_ff <= match_rank_in;
      match_val_ff  <= match_val_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_val_ff    <= rsp_val_in;
   end

   // entry memories: registered read, one write port each
   always_ff @(posedge clock) begin
      rd_key_ff  <= key_mem[idx_ff];
      rd_val_ff  <= val_mem[idx_ff];
      rd_rank_ff <= rank_mem[idx_ff];
      if (kv_wr_en) begin
         key_mem[idx_ff] <= key_ff;
      end
      if (kv_wr_en || val_wr_en) begin
         val_mem[idx_ff] <= val_ff;
      end
      if (rank_wr_en) begin
         rank_mem[idx_ff] <= rank_wr_data;
      end
   end

   // outputs
   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_val_ff;

endmodule

// ===== sim/lru_cache_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_cache_checker: lookup predictor and result checker for the lru cache
// mirrors the store, the recency ranks and the capacity register from the
// observed handshakes, queues the reply of every accepted get and compares
// each strobed result with the oldest queued reply
// ----------------------------------------------------------------------------
module lru_cache_checker #(
   parameter int MAX_ENTRIES = 16,
   parameter int KEY_BITS = 32
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   input  logic                                       busy,
   input  logic                                       req_op,
   input  logic signed [lrukv_pkg::PORT_KEY_BITS-1:0] req_key,
   input  logic signed [lrukv_pkg::VALUE_BITS-1:0]    req_value,
   input  logic                                       rsp_strobe,
   input  logic                                       rsp_hit,
   input  logic signed [lrukv_pkg::VALUE_BITS-1:0]    rsp_read_value,
   input  logic                                       csr_write_enable,
   input  logic [lrukv_pkg::CAP_BITS-1:0]             csr_write_data,
   output int                                         mismatch_count,
   output int                                         replies_pending
);

   typedef struct packed {
      logic                                    hit;
      logic signed [lrukv_pkg::VALUE_BITS-1:0] read_value;
   } get_reply_type;

   localparam logic [lrukv_pkg::PORT_KEY_BITS-1:0] KEY_MASK =
      (KEY_BITS >= lrukv_pkg::PORT_KEY_BITS) ? '1
         : ((lrukv_pkg::PORT_KEY_BITS'(1) << KEY_BITS) - 1'b1);

   // shadow copy of the store
   logic [lrukv_pkg::CAP_BITS-1:0]      capacity_reg;
   logic                                slot_used  [MAX_ENTRIES];
   logic [lrukv_pkg::PORT_KEY_BITS-1:0] slot_key   [MAX_ENTRIES];
   logic [lrukv_pkg::VALUE_BITS-1:0]    slot_value [MAX_ENTRIES];
   int unsigned                         slot_age   [MAX_ENTRIES];
   int unsigned                         used_count;

   // replies of accepted gets, oldest first
   get_reply_type get_reply_q [$];

   // capacity as the block applies it: zero acts as one, saturates at the top
   function automatic int unsigned capacity_limit();
      int unsigned c;
      c = capacity_reg;
      if (c == 0) c = 1;
      if (c > MAX_ENTRIES) c = MAX_ENTRIES;
      return c;
   endfunction

   function automatic int find_slot(logic [lrukv_pkg::PORT_KEY_BITS-1:0] k);
      for (int i = 0; i < MAX_ENTRIES; i++)
         if (slot_used[i] && slot_key[i] == k) return i;
      return -1;
   endfunction

   // entry becomes most recent, the ones more recent than it age by one
   function automatic void promote(int idx);
      int unsigned old_age;
      old_age = slot_age[idx];
      for (int i = 0; i < MAX_ENTRIES; i++)
         if (slot_used[i] && slot_age[i] < old_age) slot_age[i]++;
      slot_age[idx] = 0;
   endfunction

   // new key: evict from the old end when full, then take the lowest free slot
   function automatic void install(logic [lrukv_pkg::PORT_KEY_BITS-1:0] k,
                                   logic [lrukv_pkg::VALUE_BITS-1:0] v);
      int unsigned lim;
      int free_slot;
      lim = capacity_limit();
      free_slot = -1;
      if (used_count >= lim) begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (slot_used[i] && slot_age[i] >= lim - 1) begin
               slot_used[i] = 1'b0;
               slot_age[i] = 0;
               used_count--;
            end
         end
      end
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (slot_used[i]) slot_age[i]++;
         else if (free_slot < 0) free_slot = i;
      end
      if (free_slot >= 0) begin
         slot_used[free_slot] = 1'b1;
         slot_key[free_slot] = k;
         slot_value[free_slot] = v;
         slot_age[free_slot] = 0;
         used_count++;
      end
   endfunction

   // one accepted item: update the shadow store, queue the reply of a get
   function automatic void apply_access(logic op, logic [lrukv_pkg::PORT_KEY_BITS-1:0] key,
                                        logic [lrukv_pkg::VALUE_BITS-1:0] value);
      logic [lrukv_pkg::PORT_KEY_BITS-1:0] k;
      int idx;
      get_reply_type reply;
      k = key & KEY_MASK;
      idx = find_slot(k);
      if (op == lrukv_pkg::OP_GET) begin
         if (idx >= 0) begin
            reply.hit = 1'b1;
            reply.read_value = slot_value[idx];
            promote(idx);
         end else begin
            reply.hit = 1'b0;
            reply.read_value = lrukv_pkg::MISS_VALUE;
         end
         get_reply_q.push_back(reply);
      end else if (idx >= 0) begin
         slot_value[idx] = value;
         promote(idx);
      end else begin
         install(k, value);
      end
   endfunction

   // watch both channels and the register port at every edge
   always @(posedge clock) begin : watch
      get_reply_type want;
      if (reset) begin
         capacity_reg = lrukv_pkg::CAP_RESET;
         used_count = 0;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            slot_used[i] = 1'b0;
            slot_age[i] = 0;
         end
         get_reply_q.delete();
      end else begin
         // result first: it belongs to an item accepted earlier
         if (rsp_strobe) begin
            if (get_reply_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: result with no get waiting: hit %0b read_value %0d",
                           $realtime, rsp_hit, rsp_read_value);
            end else begin
               want = get_reply_q.pop_front();
               if (rsp_hit !== want.hit || rsp_read_value !== want.read_value) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: expected hit %0b value %0d, got hit %0b value %0d",
                              $realtime, want.hit, want.read_value, rsp_hit,
                              rsp_read_value);
               end
            end
         end
         if (csr_write_enable) capacity_reg = csr_write_data;
         if (start && !busy) apply_access(req_op, req_key, req_value);
      end
      replies_pending <= get_reply_q.size();
   end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the lru key/value cache
// directed gets and puts on key and value extremes, then random phases under
// several capacity settings with keys drawn mostly from a small pool so that
// hits, overwrites and evictions are frequent; a checker beside the block
// predicts and compares every get result
// ----------------------------------------------------------------------------
module testbench;

   localparam int MAX_ENTRIES = 16;
   localparam int KEY_BITS = 32;
   localparam int SETTLE_CYCLES = 4 * MAX_ENTRIES + 8;
   localparam int POOL_DEPTH = 24;
   localparam int ITEMS_PER_PHASE = 50;

   logic                                       clock;
   logic                                       reset;
   logic                                       start;
   logic                                       busy;
   logic                                       req_op;
   logic signed [lrukv_pkg::PORT_KEY_BITS-1:0] req_key;
   logic signed [lrukv_pkg::VALUE_BITS-1:0]    req_value;
   logic                                       rsp_strobe;
   logic                                       rsp_hit;
   logic signed [lrukv_pkg::VALUE_BITS-1:0]    rsp_read_value;
   logic                                       csr_write_enable;
   logic [lrukv_pkg::CAP_BITS-1:0]             csr_write_data;

   int mismatch_count;
   int replies_pending;

   logic [lrukv_pkg::PORT_KEY_BITS-1:0] key_pool [POOL_DEPTH];
   int pool_size;
   int idle_pct;

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   lru_key_value_cache #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .KEY_BITS(KEY_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_key(req_key),
      .req_value(req_value),
      .rsp_strobe(rsp_strobe),
      .rsp_hit(rsp_hit),
      .rsp_read_value(rsp_read_value),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   lru_cache_checker #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .KEY_BITS(KEY_BITS)
   ) i_checker (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_key(req_key),
      .req_value(req_value),
      .rsp_strobe(rsp_strobe),
      .rsp_hit(rsp_hit),
      .rsp_read_value(rsp_read_value),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .mismatch_count(mismatch_count),
      .replies_pending(replies_pending)
   );

   // present one item and hold it until the block takes it, then maybe idle
   task automatic send_item(input logic op,
                            input logic [lrukv_pkg::PORT_KEY_BITS-1:0] key,
                            input logic [lrukv_pkg::VALUE_BITS-1:0] value);
      start <= 1'b1;
      req_op <= op;
      req_key <= key;
      req_value <= value;
      do @(posedge clock); while (busy);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         req_op <= 1'($urandom);
         req_key <= $urandom;
         req_value <= $urandom;
         repeat ($urandom_range(1, 90)) @(posedge clock);
      end
   endtask

   // mostly pool keys so that the store sees hits and evictions
   task automatic send_random_item();
      logic [lrukv_pkg::PORT_KEY_BITS-1:0] key;
      if ($urandom_range(99) < 85) key = key_pool[$urandom_range(pool_size - 1)];
      else key = $urandom;
      send_item(1'($urandom), key, $urandom);
   endtask

   // capacity write once the block is idle: no get pending and no put in flight
   task automatic write_capacity(input logic [lrukv_pkg::CAP_BITS-1:0] cap);
      start <= 1'b0;
      do @(posedge clock); while (replies_pending != 0 || busy);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= cap;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      csr_write_data <= lrukv_pkg::CAP_BITS'($urandom);
   endtask

   // stimulus
   initial begin
      logic [lrukv_pkg::CAP_BITS-1:0] cap_plan [8];
      int eff_cap;
      reset <= 1'b1;
      start <= 1'b0;
      req_op <= lrukv_pkg::OP_GET;
      req_key <= '0;
      req_value <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data <= '0;
      idle_pct = 20;
      cap_plan = '{5'd2, 5'd0, 5'd31, 5'd1, 5'd5, 5'd16, 5'd9, 5'd3};
      foreach (key_pool[i]) key_pool[i] = $urandom;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      pool_size = POOL_DEPTH;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty store, field extremes, overwrite, miss
      send_item(lrukv_pkg::OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
      send_item(lrukv_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(lrukv_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(lrukv_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(lrukv_pkg::OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
      send_item(lrukv_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
      send_item(lrukv_pkg::OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_item(lrukv_pkg::OP_GET, 32'hFFFF_FFFF, 32'h5555_5555);
      send_item(lrukv_pkg::OP_GET, 32'h0000_0000, 32'hAAAA_AAAA);
      send_item(lrukv_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
      send_item(lrukv_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
      send_item(lrukv_pkg::OP_GET, 32'h0000_0001, 32'h0000_0000);

      // capacity lowered below the number of valid entries
      write_capacity(5'd2);
      send_item(lrukv_pkg::OP_PUT, 32'h0000_0005, 32'hDEAD_BEEF);
      send_item(lrukv_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
      send_item(lrukv_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
      send_item(lrukv_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(lrukv_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
      send_item(lrukv_pkg::OP_GET, 32'h0000_0005, 32'h0000_0000);

      // random phases, one per capacity setting; one phase never idles
      for (int p = 0; p < 8; p++) begin
         write_capacity(cap_plan[p]);
         eff_cap = (cap_plan[p] == 0) ? 1 :
                   (cap_plan[p] > MAX_ENTRIES) ? MAX_ENTRIES : cap_plan[p];
         pool_size = eff_cap + 4;
         idle_pct = (p == 5) ? 0 : 20;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random_item();
      end

      // drain and give the verdict
      start <= 1'b0;
      do @(posedge clock); while (replies_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && replies_pending == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("testbench NOT OK");
      $finish;
   end

endmodule

// ===== files.f =====
src/lrukv_pkg.sv
src/lru_key_value_cache.sv
sim/lru_cache_checker.sv
sim/testbench.sv
